// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the core RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/scc_pkg.sv
// ---------------------------------------------------------------------------
// SCC package
// Sizes, command codes and beat types of the component search core.
// ---------------------------------------------------------------------------
package scc_pkg;
    localparam int MaxNodes  = 32;
    localparam int MaxDegree = 32;
    localparam int NodeW     = $clog2(MaxNodes);
    localparam int EdgeW     = $clog2(MaxDegree);
    localparam int DegW      = EdgeW + 1;
    localparam int CountW    = NodeW + 1;
    localparam int AdjAddrW  = NodeW + EdgeW;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] src_node;
        logic [4:0] dst_node;
    } in_beat_t;

    typedef struct packed {
        logic       status;
        logic [4:0] member_node;
        logic       end_of_circle;
        logic       last;
    } out_beat_t;
endpackage

// File: rtl/core/scc_if.sv
// ---------------------------------------------------------------------------
// SCC stream interfaces
// Valid/ready channels carrying command and result beats.
// ---------------------------------------------------------------------------
interface scc_in_if;
    import scc_pkg::*;
    logic     valid;
    logic     ready;
    in_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface scc_out_if;
    import scc_pkg::*;
    logic      valid;
    logic      ready;
    out_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/strongly_connected_components_core.sv
// ---------------------------------------------------------------------------
// Strongly connected components core
// Tarjan component search over a loaded directed graph.
// ---------------------------------------------------------------------------
// Usage: cmd channel takes beats of command/src_node/dst_node. Add edge
// appends dst to src's list; a full list gives one result beat with
// status 1. Clear empties all lists. Run walks all nodes and edges
// through one sequencer sharing an adjacency memory port and a low-link
// compare: S_INIT, then S_ROOT per root index, S_FRAME/S_EDGE/S_CHECK
// per edge, S_RET/S_PARENT per returning node, S_POP per popped member
// while the receiver takes beats. Results come on the res channel in pop
// order, end_of_circle on a component's root, last on the final beat. A
// stalled receiver holds the sequencer: the block accepts no beat while a
// result waits. node_count is written by cfg_we/cfg_data; the user must do
// so only while idle; the block does not enforce it. Reset empties all lists
// and sets node_count to 32; adjacency memory contents are not cleared.
// ---------------------------------------------------------------------------
module strongly_connected_components_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [5:0] cfg_data,
    scc_in_if.sink     cmd,
    scc_out_if.source  res
);
    import scc_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_ROOT, S_FRAME, S_EDGE, S_CHECK, S_RET,
        S_POP, S_PARENT
    } state_t;

    state_t state_reg;
    logic [5:0] ncount_reg;
    logic [CountW-1:0] neff;
    logic [DegW-1:0] deg_reg [MaxNodes];
    logic [NodeW-1:0] adj_mem [MaxNodes*MaxDegree];
    logic [NodeW-1:0] adj_q;
    logic [CountW-1:0] disc_reg [MaxNodes];
    logic [CountW-1:0] low_reg [MaxNodes];
    logic [MaxNodes-1:0] visited_reg, onstk_reg;
    logic [NodeW-1:0] cstk_mem [MaxNodes];
    logic [NodeW-1:0] fnode_mem [MaxNodes];
    logic [DegW-1:0] fedge_mem [MaxNodes];
    logic [CountW-1:0] csp_reg, fsp_reg, vcnt_reg;
    logic [CountW-1:0] root_reg;
    logic [NodeW-1:0] v_reg;
    logic [DegW-1:0] i_reg;
    logic [CountW-1:0] emitted_reg;
    out_beat_t res_reg;
    logic res_valid_reg;
    logic res_load;

    assign neff = (ncount_reg > 6'(MaxNodes)) ? CountW'(MaxNodes) : ncount_reg[CountW-1:0];
    assign cmd.ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    assign res_load = ((state_reg == S_IDLE) && cmd.valid && cmd.ready
                       && cmd.data.command == CMD_ADD
                       && deg_reg[cmd.data.src_node] >= DegW'(MaxDegree))
                   || ((state_reg == S_POP) && csp_reg != '0
                       && (!res_valid_reg || res.ready));

    logic [NodeW-1:0] ftop_node;
    logic [DegW-1:0]  ftop_edge;
    logic [NodeW-1:0] ctop;
    assign ftop_node = fnode_mem[fsp_reg[NodeW-1:0] - NodeW'(1)];
    assign ftop_edge = fedge_mem[fsp_reg[NodeW-1:0] - NodeW'(1)];
    assign ctop      = cstk_mem[csp_reg[NodeW-1:0] - NodeW'(1)];

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready && cmd.data.command == CMD_ADD
            && deg_reg[cmd.data.src_node] < DegW'(MaxDegree))
            adj_mem[{cmd.data.src_node, deg_reg[cmd.data.src_node][EdgeW-1:0]}]
                <= cmd.data.dst_node;
        adj_q <= adj_mem[{v_reg, i_reg[EdgeW-1:0]}];
    end

    task automatic push_visit(input logic [NodeW-1:0] n);
    begin
        disc_reg[n] <= vcnt_reg;
        low_reg[n]  <= vcnt_reg;
        vcnt_reg    <= vcnt_reg + CountW'(1);
        visited_reg[n] <= 1'b1;
        onstk_reg[n]   <= 1'b1;
        cstk_mem[csp_reg[NodeW-1:0]] <= n;
        csp_reg <= csp_reg + CountW'(1);
        fnode_mem[fsp_reg[NodeW-1:0]] <= n;
        fedge_mem[fsp_reg[NodeW-1:0]] <= '0;
        fsp_reg <= fsp_reg + CountW'(1);
    end
    endtask

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ncount_reg <= 6'd32;
            for (int k = 0; k < MaxNodes; k++)
                deg_reg[k] <= '0;
            visited_reg <= '0;
            onstk_reg <= '0;
            csp_reg <= '0;
            fsp_reg <= '0;
            vcnt_reg <= '0;
            root_reg <= '0;
            v_reg <= '0;
            i_reg <= '0;
            res_reg <= '0;
            res_valid_reg <= 1'b0;
            emitted_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                ncount_reg <= cfg_data;
            if (res_valid_reg && res.ready && !res_load)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid && cmd.ready)
                    begin
                        unique case (cmd.data.command)
                            CMD_ADD:
                            begin
                                if (deg_reg[cmd.data.src_node] < DegW'(MaxDegree))
                                    deg_reg[cmd.data.src_node] <=
                                        deg_reg[cmd.data.src_node] + DegW'(1);
                                else
                                begin
                                    res_reg <= '{1'b1, cmd.data.src_node, 1'b0, 1'b1};
                                    res_valid_reg <= 1'b1;
                                end
                            end
                            CMD_RUN: state_reg <= S_INIT;
                            CMD_CLEAR:
                                for (int k = 0; k < MaxNodes; k++)
                                    deg_reg[k] <= '0;
                            default: ;
                        endcase
                    end
                end
                S_INIT:
                begin
                    visited_reg <= '0;
                    onstk_reg <= '0;
                    csp_reg <= '0;
                    fsp_reg <= '0;
                    vcnt_reg <= '0;
                    root_reg <= '0;
                    emitted_reg <= '0;
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (root_reg >= neff)
                        state_reg <= S_IDLE;
                    else
                    begin
                        if (!visited_reg[root_reg[NodeW-1:0]])
                        begin
                            push_visit(root_reg[NodeW-1:0]);
                            state_reg <= S_FRAME;
                        end
                        root_reg <= root_reg + CountW'(1);
                    end
                end
                S_FRAME:
                begin
                    if (fsp_reg == '0)
                        state_reg <= S_ROOT;
                    else
                    begin
                        v_reg <= ftop_node;
                        i_reg <= ftop_edge;
                        if (ftop_edge < deg_reg[ftop_node])
                        begin
                            fedge_mem[fsp_reg[NodeW-1:0] - NodeW'(1)] <= ftop_edge + DegW'(1);
                            state_reg <= S_EDGE;
                        end
                        else
                            state_reg <= S_RET;
                    end
                end
                S_EDGE: state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if ({1'b0, adj_q} < neff)
                    begin
                        if (!visited_reg[adj_q])
                            push_visit(adj_q);
                        else if (onstk_reg[adj_q] && disc_reg[adj_q] < low_reg[v_reg])
                            low_reg[v_reg] <= disc_reg[adj_q];
                    end
                    state_reg <= S_FRAME;
                end
                S_RET:
                    state_reg <= (low_reg[v_reg] == disc_reg[v_reg]) ? S_POP : S_PARENT;
                S_POP:
                begin
                    if (csp_reg == '0)
                        state_reg <= S_PARENT;
                    else if (!res_valid_reg || res.ready)
                    begin
                        res_reg <= '{1'b0, ctop, ctop == v_reg,
                                     emitted_reg + CountW'(1) == neff};
                        res_valid_reg <= 1'b1;
                        onstk_reg[ctop] <= 1'b0;
                        csp_reg <= csp_reg - CountW'(1);
                        emitted_reg <= emitted_reg + CountW'(1);
                        state_reg <= (ctop == v_reg) ? S_PARENT : S_POP;
                    end
                end
                S_PARENT:
                begin
                    fsp_reg <= fsp_reg - CountW'(1);
                    if (fsp_reg > CountW'(1)
                        && low_reg[v_reg] < low_reg[fnode_mem[fsp_reg[NodeW-1:0] - NodeW'(2)]])
                        low_reg[fnode_mem[fsp_reg[NodeW-1:0] - NodeW'(2)]] <= low_reg[v_reg];
                    state_reg <= S_FRAME;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEVER(a_ready_busy, clk, rst_n, cmd.ready && state_reg != S_IDLE)
    `ASSERT_NEVER(a_fsp_over, clk, rst_n, fsp_reg > CountW'(MaxNodes))
    `ASSERT_NEVER(a_csp_over, clk, rst_n, csp_reg > CountW'(MaxNodes))
    `ASSERT_IMPL(a_run_start, clk, rst_n,
        (cmd.valid && cmd.ready && cmd.data.command == CMD_RUN) |=> state_reg == S_INIT)
endmodule
